>>> rtl/core/dsee_pkg.sv
// Package for the differential syndrome ECC encoder.
// Holds the payload types, register indexes, the derived code layout type and fixed widths.
// Has no dependencies; every other file of the block but dsee_stream_if imports it.
package dsee_pkg;

    // Fixed widths of the channel fields and of the configuration port.
    localparam int FIELD_W    = 16;
    localparam int CFG_W      = 3;
    localparam int CFG_IDX_W  = 3;

    // Syndrome values never need more than eight bits.
    localparam int SYND_W     = 8;
    localparam int SIZE_REGS  = 4;
    localparam int NUM_REGS   = 5;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_3 = 3'd4;

    // Register values after reset.
    localparam logic [CFG_W-1:0] RST_BLOCK_COUNT  = 3'd2;
    localparam logic [CFG_W-1:0] RST_BLOCK_SIZE_0 = 3'd2;
    localparam logic [CFG_W-1:0] RST_BLOCK_SIZE_1 = 3'd3;
    localparam logic [CFG_W-1:0] RST_BLOCK_SIZE_2 = 3'd1;
    localparam logic [CFG_W-1:0] RST_BLOCK_SIZE_3 = 3'd1;

    // Last syndrome value visited by the data column sweep.
    localparam logic [SYND_W-1:0] SWEEP_LAST = 8'hFF;

    // Input word payload.
    typedef struct packed {
        logic [FIELD_W-1:0] data_in;
    } word_t;

    // Result payload.
    typedef struct packed {
        logic [FIELD_W-1:0] data_out;
        logic [FIELD_W-1:0] redundancy_out;
        logic               config_fault;
    } result_t;

    // Code layout worked out from the configuration registers.
    typedef struct packed {
        logic [2:0]                       used;
        logic                             fault;
        logic [3:0]                       total;
        logic [SIZE_REGS-1:0][3:0]        boff;
        logic [SIZE_REGS-1:0][8:0]        coff;
        logic [SIZE_REGS-1:0][SYND_W-1:0] mask;
        logic [SIZE_REGS-1:0][SYND_W-1:0] nv;
    } layout_t;

endpackage

>>> rtl/core/dsee_stream_if.sv
// Valid/ready stream interface used for the word and result channels.
// Depends on nothing; the payload type is given by the instantiating module.
interface dsee_stream_if #(
    parameter type payload_t = logic [0:0]
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

>>> rtl/core/dsee_cfg.sv
// Configuration registers and code layout for the differential syndrome ECC encoder.
// Depends on dsee_pkg. Produces the registered layout and the redundancy column tables.
module dsee_cfg
    import dsee_pkg::*;
#(
    parameter int RED_BITS   = 16,
    parameter int MAX_BLOCKS = 4,
    parameter int SYND_BITS  = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]             cfg_index,
    input  logic [CFG_W-1:0]                 cfg_wdata,
    output logic                             restart,
    output layout_t                          layout,
    output logic [RED_BITS-1:0][SYND_W-1:0]  red_col,
    output logic [RED_BITS-1:0][SYND_W-1:0]  red_mask
);

    localparam int LIMIT = (MAX_BLOCKS < SIZE_REGS) ? MAX_BLOCKS : SIZE_REGS;
    localparam logic [CFG_W-1:0] LIMIT_C = CFG_W'(LIMIT);
    localparam logic [4:0]       SYND_LIM = 5'(SYND_BITS);
    localparam logic [9:0]       RED_LIM  = 10'(RED_BITS);

    logic [CFG_W-1:0]                block_count_reg;
    logic [SIZE_REGS-1:0][CFG_W-1:0] size_reg;
    layout_t                         layout_next;
    layout_t                         layout_reg;
    logic [RED_BITS-1:0][SYND_W-1:0] red_col_next;
    logic [RED_BITS-1:0][SYND_W-1:0] red_col_reg;
    logic [RED_BITS-1:0][SYND_W-1:0] red_mask_next;
    logic [RED_BITS-1:0][SYND_W-1:0] red_mask_reg;

    // Register writes; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= RST_BLOCK_COUNT;
            size_reg[0]     <= RST_BLOCK_SIZE_0;
            size_reg[1]     <= RST_BLOCK_SIZE_1;
            size_reg[2]     <= RST_BLOCK_SIZE_2;
            size_reg[3]     <= RST_BLOCK_SIZE_3;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_BLOCK_COUNT:  block_count_reg <= cfg_wdata;
                REG_BLOCK_SIZE_0: size_reg[0]     <= cfg_wdata;
                REG_BLOCK_SIZE_1: size_reg[1]     <= cfg_wdata;
                REG_BLOCK_SIZE_2: size_reg[2]     <= cfg_wdata;
                REG_BLOCK_SIZE_3: size_reg[3]     <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // Any write to a real register rebuilds the data column table.
    assign restart = cfg_wr_en && (cfg_index <= REG_BLOCK_SIZE_3);

    // Block fields, offsets and the fault flag.
    always_comb
    begin
        logic [CFG_W-1:0] nb;
        logic             stop;
        logic [4:0]       tot;
        logic [8:0]       dc;
        logic [CFG_W-1:0] m;

        layout_next = '0;
        stop        = 1'b0;
        tot         = '0;
        dc          = '0;
        nb          = block_count_reg;
        if (nb == '0)
        begin
            layout_next.fault = 1'b1;
        end
        if (nb > LIMIT_C)
        begin
            layout_next.fault = 1'b1;
            nb = LIMIT_C;
        end
        for (int b = 0; b < SIZE_REGS; b++)
        begin
            m = size_reg[b];
            if ((CFG_W'(b) < nb) && !stop)
            begin
                if (m == '0 || m > 3'd4)
                begin
                    layout_next.fault = 1'b1;
                end
                if ({2'b00, m} + tot > SYND_LIM)
                begin
                    layout_next.fault = 1'b1;
                    stop = 1'b1;
                end
                else
                begin
                    layout_next.boff[b] = tot[3:0];
                    layout_next.coff[b] = dc;
                    layout_next.nv[b]   = SYND_W'((9'd1 << m) - 9'd1);
                    layout_next.mask[b] = SYND_W'(((9'd1 << m) - 9'd1) << tot);
                    dc  = dc + ((9'd1 << m) - 9'd1);
                    tot = tot + {2'b00, m};
                    layout_next.used = layout_next.used + 3'd1;
                end
            end
        end
        layout_next.total = tot[3:0];
        if ({1'b0, dc} > RED_LIM)
        begin
            layout_next.fault = 1'b1;
        end
    end

    // Syndrome value and block mask of each redundancy bit.
    always_comb
    begin
        logic [8:0] v;

        red_col_next  = '0;
        red_mask_next = '0;
        for (int i = 0; i < RED_BITS; i++)
        begin
            for (int b = 0; b < SIZE_REGS; b++)
            begin
                v = 9'(i) - layout_reg.coff[b] + 9'd1;
                if ((3'(b) < layout_reg.used) && (9'(i) >= layout_reg.coff[b]) &&
                    (9'(i) < layout_reg.coff[b] + {1'b0, layout_reg.nv[b]}))
                begin
                    red_col_next[i]  = SYND_W'(v[SYND_W-1:0] << layout_reg.boff[b]);
                    red_mask_next[i] = layout_reg.mask[b];
                end
            end
        end
    end

    // Layout and column tables are rebuilt every cycle from the registers.
    always_ff @(posedge clk)
    begin
        layout_reg   <= layout_next;
        red_col_reg  <= red_col_next;
        red_mask_reg <= red_mask_next;
    end

    assign layout   = layout_reg;
    assign red_col  = red_col_reg;
    assign red_mask = red_mask_reg;

endmodule

>>> rtl/core/dsee_colgen.sv
// Data column table builder for the differential syndrome ECC encoder.
// Depends on dsee_pkg. Sweeps all syndrome values once after reset and after each write to a mapped register.
module dsee_colgen
    import dsee_pkg::*;
#(
    parameter int DCOLS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          restart,
    input  layout_t                       layout,
    output logic                          busy,
    output logic [DCOLS-1:0][SYND_W-1:0]  data_col
);

    localparam int KW = $clog2(DCOLS + 1);
    localparam logic [KW-1:0] DCOLS_C = KW'(DCOLS);

    logic [SYND_W-1:0]              val_reg;
    logic                           busy_reg;
    logic [KW-1:0]                  k_reg;
    logic [DCOLS-1:0][SYND_W-1:0]   col_reg;
    logic                           confined;
    logic                           take;
    logic [8:0]                     maxval;

    // A value lies inside one block when it has no bits outside that block's field.
    always_comb
    begin
        confined = 1'b0;
        for (int b = 0; b < SIZE_REGS; b++)
        begin
            if ((3'(b) < layout.used) && ((val_reg & ~layout.mask[b]) == '0))
            begin
                confined = 1'b1;
            end
        end
    end

    assign maxval = (9'd1 << layout.total) - 9'd1;
    assign take   = busy_reg && (val_reg != '0) && !confined && (k_reg < DCOLS_C) &&
                    ({1'b0, val_reg} <= maxval);

    // Sweep control: value counter and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            val_reg  <= '0;
            k_reg    <= '0;
        end
        else if (restart)
        begin
            busy_reg <= 1'b1;
            val_reg  <= '0;
            k_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (val_reg == '0)
            begin
                k_reg <= '0;
            end
            else if (take)
            begin
                k_reg <= k_reg + KW'(1);
            end
            if (val_reg == SWEEP_LAST)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                val_reg <= val_reg + SYND_W'(1);
            end
        end
    end

    // Table entries: cleared at the start of a sweep, then filled in ascending order.
    always_ff @(posedge clk)
    begin
        if (busy_reg && (val_reg == '0))
        begin
            col_reg <= '0;
        end
        else if (take)
        begin
            for (int j = 0; j < DCOLS; j++)
            begin
                if (k_reg == KW'(j))
                begin
                    col_reg[j] <= val_reg;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign data_col = col_reg;

endmodule

>>> rtl/core/dsee_datapath.sv
// Word pipeline of the differential syndrome ECC encoder: input register, syndrome
// logic, redundancy state and result register. Depends on dsee_pkg and dsee_stream_if.
module dsee_datapath
    import dsee_pkg::*;
#(
    parameter int RED_BITS = 16,
    parameter int DCOLS    = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             busy,
    input  logic                             fault,
    input  logic [DCOLS-1:0][SYND_W-1:0]     data_col,
    input  logic [RED_BITS-1:0][SYND_W-1:0]  red_col,
    input  logic [RED_BITS-1:0][SYND_W-1:0]  red_mask,
    dsee_stream_if.sink                      word,
    dsee_stream_if.source                    result
);

    localparam int RED_OUT = (RED_BITS < FIELD_W) ? RED_BITS : FIELD_W;

    logic                  in_vld_reg;
    logic [DCOLS-1:0]      data_reg;
    logic                  res_vld_reg;
    result_t               res_reg;
    result_t               res_next;
    logic [RED_BITS-1:0]   red_reg;
    logic [RED_BITS-1:0]   red_next;
    logic                  advance;
    logic                  accept;
    logic [SYND_W-1:0]     sdata;
    logic [SYND_W-1:0]     sred;
    logic [SYND_W-1:0]     gap;

    assign advance     = in_vld_reg && (!res_vld_reg || result.ready);
    assign word.ready  = !busy && (!in_vld_reg || advance);
    assign accept      = word.valid && word.ready;

    // Syndromes, gap and the per-block flip of the redundancy bits.
    always_comb
    begin
        sdata = '0;
        sred  = '0;
        for (int k = 0; k < DCOLS; k++)
        begin
            if (data_reg[k])
            begin
                sdata = sdata ^ data_col[k];
            end
        end
        for (int i = 0; i < RED_BITS; i++)
        begin
            if (red_reg[i])
            begin
                sred = sred ^ red_col[i];
            end
        end
        gap = sdata ^ sred;
        for (int i = 0; i < RED_BITS; i++)
        begin
            red_next[i] = red_reg[i] ^ ((red_col[i] != '0) &&
                                        ((gap & red_mask[i]) == red_col[i]));
        end
    end

    // Result payload: the word as taken, the updated redundancy and the fault flag.
    always_comb
    begin
        res_next                              = '0;
        res_next.data_out[DCOLS-1:0]          = data_reg;
        res_next.redundancy_out[RED_OUT-1:0]  = red_next[RED_OUT-1:0];
        res_next.config_fault                 = fault;
    end

    // Control state and the redundancy register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
            red_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end
            if (advance)
            begin
                res_vld_reg <= 1'b1;
                red_reg     <= red_next;
            end
            else if (result.ready)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= word.payload.data_in[DCOLS-1:0];
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid   = res_vld_reg;
    assign result.payload = res_reg;

endmodule

>>> rtl/core/differential_syndrome_ecc_encoder.sv
// Differential syndrome ECC encoder, top level. Each word goes through the input register
// and then the result register. Throughput: one word per cycle while no table build runs,
// set by the single pass from the input register through the syndrome XOR network to the
// result register; a stalled result holds the input off. Reset clears the redundancy register
// and loads the register defaults; after reset and after every write to a mapped register a
// data column table build holds ready low. Depends on dsee_pkg, dsee_stream_if and the cores.
module differential_syndrome_ecc_encoder
    import dsee_pkg::*;
#(
    parameter int DATA_BITS  = 16,
    parameter int RED_BITS   = 16,
    parameter int MAX_BLOCKS = 4,
    parameter int SYND_BITS  = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    dsee_stream_if.sink          word,
    dsee_stream_if.source        result
);

    // Only data columns that a 16-bit word can select are kept.
    localparam int DCOLS = (DATA_BITS < FIELD_W) ? DATA_BITS : FIELD_W;

    logic                            restart;
    logic                            busy;
    layout_t                         layout;
    logic [RED_BITS-1:0][SYND_W-1:0] red_col;
    logic [RED_BITS-1:0][SYND_W-1:0] red_mask;
    logic [DCOLS-1:0][SYND_W-1:0]    data_col;

    // Registers and code layout.
    dsee_cfg #(
        .RED_BITS   (RED_BITS),
        .MAX_BLOCKS (MAX_BLOCKS),
        .SYND_BITS  (SYND_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .restart   (restart),
        .layout    (layout),
        .red_col   (red_col),
        .red_mask  (red_mask)
    );

    // Data column table.
    dsee_colgen #(
        .DCOLS (DCOLS)
    ) u_colgen (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (restart),
        .layout   (layout),
        .busy     (busy),
        .data_col (data_col)
    );

    // Word pipeline.
    dsee_datapath #(
        .RED_BITS (RED_BITS),
        .DCOLS    (DCOLS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .busy     (busy),
        .fault    (layout.fault),
        .data_col (data_col),
        .red_col  (red_col),
        .red_mask (red_mask),
        .word     (word),
        .result   (result)
    );

endmodule

>>> tb/differential_syndrome_ecc_encoder_tb.sv
// Self-checking testbench for the differential syndrome ECC encoder.
// Drives words and register writes, predicts each result in place and checks every transfer.
// Depends on dsee_pkg, dsee_stream_if and the differential_syndrome_ecc_encoder top level.
`timescale 1ns / 100ps

module differential_syndrome_ecc_encoder_tb;
    import dsee_pkg::*;

    localparam int DATA_BITS  = 16;
    localparam int RED_BITS   = 16;
    localparam int MAX_BLOCKS = 4;
    localparam int SYND_BITS  = 8;

    // Blocks beyond this count are never used, whatever the block count register says.
    localparam int BLOCK_LIMIT = (MAX_BLOCKS < SIZE_REGS) ? MAX_BLOCKS : SIZE_REGS;

    // Indexes with no register behind them; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    localparam int ITEM_TARGET  = 1750;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN,
        STALL_HEAVY
    } stall_mode_e;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    dsee_stream_if #(.payload_t(word_t))   word_ch ();
    dsee_stream_if #(.payload_t(result_t)) result_ch ();

    // Predictor state: the redundancy register and a copy of the configuration.
    logic [RED_BITS-1:0] red_state;
    logic [CFG_W-1:0]    code_regs [NUM_REGS];

    result_t     expected_results [$];
    result_t     got_result;
    result_t     want_result;
    int unsigned mismatch_count = 0;
    int unsigned words_sent;
    int unsigned cycle_count = 0;
    int unsigned burst_left;
    int unsigned stall_left = 0;
    int unsigned stall_phase = 0;
    stall_mode_e stall_mode = STALL_NONE;

    differential_syndrome_ecc_encoder #(
        .DATA_BITS  (DATA_BITS),
        .RED_BITS   (RED_BITS),
        .MAX_BLOCKS (MAX_BLOCKS),
        .SYND_BITS  (SYND_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .word      (word_ch),
        .result    (result_ch)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Encode one word against the predictor state and advance the redundancy register.
    function automatic result_t encode_word(input logic [FIELD_W-1:0] data);
        int unsigned blocks;
        int unsigned used;
        int unsigned total;
        int unsigned dcols;
        int unsigned maxval;
        int unsigned k;
        int unsigned col;
        int unsigned m;
        int unsigned sdata;
        int unsigned sred;
        int unsigned gap;
        int unsigned chunk;
        int unsigned boff  [SIZE_REGS];
        int unsigned bsize [SIZE_REGS];
        int unsigned coff  [SIZE_REGS];
        int unsigned bmask [SIZE_REGS];
        logic                fault;
        logic                in_block;
        logic [RED_BITS-1:0] red;
        result_t             res;

        used  = 0;
        total = 0;
        dcols = 0;
        sdata = 0;
        sred  = 0;
        fault = 1'b0;
        red   = red_state;

        // Layout of the blocks: offsets, masks and first redundancy column of each.
        blocks = 32'(code_regs[REG_BLOCK_COUNT]);
        if (blocks == 0)
            fault = 1'b1;
        if (blocks > BLOCK_LIMIT)
        begin
            fault  = 1'b1;
            blocks = BLOCK_LIMIT;
        end
        for (int b = 0; b < blocks; b++)
        begin
            m = 32'(code_regs[REG_BLOCK_SIZE_0 + b]);
            if (m == 0 || m > 4)
                fault = 1'b1;
            if (total + m > SYND_BITS)
            begin
                fault = 1'b1;
                break;
            end
            boff[b]  = total;
            bsize[b] = m;
            coff[b]  = dcols;
            bmask[b] = ((1 << m) - 1) << total;
            dcols    = dcols + (1 << m) - 1;
            total    = total + m;
            used++;
        end
        if (dcols > RED_BITS)
            fault = 1'b1;

        // Syndrome of the redundancy bits that are set.
        for (int b = 0; b < used; b++)
        begin
            for (int unsigned v = 1; v < (1 << bsize[b]); v++)
            begin
                col = coff[b] + v - 1;
                if (col < RED_BITS && red[col])
                    sred = sred ^ (v << boff[b]);
            end
        end

        // Syndrome of the data bits; data columns are the values outside every block.
        maxval = (1 << total) - 1;
        k = 0;
        for (int unsigned v = 1; v <= maxval && k < DATA_BITS; v++)
        begin
            in_block = 1'b0;
            for (int b = 0; b < used; b++)
                if ((v & ~bmask[b]) == 0)
                    in_block = 1'b1;
            if (!in_block)
            begin
                if (data[k])
                    sdata = sdata ^ v;
                k++;
            end
        end

        // One flip per block whose share of the gap is nonzero.
        gap = sdata ^ sred;
        for (int b = 0; b < used; b++)
        begin
            chunk = gap & bmask[b];
            if (chunk != 0)
            begin
                col = coff[b] + (chunk >> boff[b]) - 1;
                if (col < RED_BITS)
                    red[col] = ~red[col];
            end
        end

        red_state          = red;
        res.data_out       = data;
        res.redundancy_out = red;
        res.config_fault   = fault;
        return res;
    endfunction

    // Word content: mostly uniform, with zero, all ones, single-bit and single-zero patterns mixed in.
    function automatic logic [FIELD_W-1:0] random_word();
        logic [FIELD_W-1:0] w;
        case ($urandom_range(0, 9))
            0: w = '0;
            1: w = '1;
            2: w = FIELD_W'(1) << $urandom_range(0, FIELD_W - 1);
            3: w = ~(FIELD_W'(1) << $urandom_range(0, FIELD_W - 1));
            default: w = FIELD_W'($urandom);
        endcase
        return w;
    endfunction

    // Offer one word, wait for its transfer, record the prediction, then maybe pause.
    task automatic send_word(input logic [FIELD_W-1:0] data);
        int unsigned gap;
        word_ch.valid   <= 1'b1;
        word_ch.payload <= '{data_in: data};
        @(posedge clk);
        while (!word_ch.ready)
            @(posedge clk);
        expected_results.push_back(encode_word(data));
        words_sent++;

        // Bursts of random length separated by random gaps, with long bursts now and then.
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 15) == 0)
                gap = $urandom_range(10, 20);
            if (gap > 0)
            begin
                word_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(0, 8);
        end
    endtask

    // Hold the sender off until every predicted result has been checked.
    task automatic wait_for_results();
        word_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; the caller lowers the write enable after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        if (idx < NUM_REGS)
            code_regs[idx] = value;
    endtask

    // Reprogram the whole code once the block has gone idle.
    task automatic load_layout(input logic [CFG_W-1:0] blocks, input logic [CFG_W-1:0] s0,
                               input logic [CFG_W-1:0] s1, input logic [CFG_W-1:0] s2,
                               input logic [CFG_W-1:0] s3);
        wait_for_results();
        write_reg(REG_BLOCK_COUNT, blocks);
        write_reg(REG_BLOCK_SIZE_0, s0);
        write_reg(REG_BLOCK_SIZE_1, s1);
        write_reg(REG_BLOCK_SIZE_2, s2);
        write_reg(REG_BLOCK_SIZE_3, s3);
        cfg_wr_en <= 1'b0;
    endtask

    // Directed words at the reset layout: extremes, alternating patterns and a walking one.
    task automatic test_reset_layout();
        send_word('0);
        send_word('1);
        send_word(16'hAAAA);
        send_word(16'h5555);
        for (int i = 0; i < FIELD_W; i++)
            send_word(FIELD_W'(1) << i);
    endtask

    // Layouts that hit each corner of the configuration, with a burst of words on each.
    task automatic test_special_layouts();
        logic [CFG_W-1:0] layouts [12][5];
        layouts = '{
            '{3'd0, 3'd2, 3'd2, 3'd2, 3'd2},   // no blocks at all
            '{3'd7, 3'd1, 3'd1, 3'd1, 3'd1},   // count above the limit, cut to four
            '{3'd5, 3'd2, 3'd2, 3'd2, 3'd2},   // count above the limit, syndrome exactly full
            '{3'd3, 3'd2, 3'd0, 3'd3, 3'd1},   // a block of size zero
            '{3'd1, 3'd7, 3'd1, 3'd1, 3'd1},   // oversized block, too many columns
            '{3'd2, 3'd5, 3'd3, 3'd1, 3'd1},   // oversized block that still fits
            '{3'd4, 3'd4, 3'd4, 3'd4, 3'd4},   // syndrome too wide, later blocks dropped
            '{3'd4, 3'd3, 3'd3, 3'd3, 3'd1},   // third block runs past the syndrome
            '{3'd2, 3'd4, 3'd4, 3'd1, 3'd1},   // thirty redundancy columns
            '{3'd1, 3'd1, 3'd0, 3'd0, 3'd0},   // smallest code, no data columns
            '{3'd4, 3'd1, 3'd1, 3'd1, 3'd1},   // all single-bit blocks
            '{3'd4, 3'd2, 3'd2, 3'd2, 3'd2}    // many data columns, shortened
        };
        foreach (layouts[i])
        begin
            load_layout(layouts[i][0], layouts[i][1], layouts[i][2], layouts[i][3],
                        layouts[i][4]);
            repeat (30) send_word(random_word());
        end
    endtask

    // Writes to indexes with no register must leave the code as it is.
    task automatic test_unmapped_index();
        load_layout(3'd3, 3'd1, 3'd3, 3'd2, 3'd4);
        @(posedge clk);
        write_reg(REG_UNMAPPED_LO, 3'd0);
        write_reg(REG_UNMAPPED_HI, 3'd7);
        cfg_wr_en <= 1'b0;
        repeat (20) send_word(random_word());
    endtask

    // Random layouts, mostly legal, each carrying a random run of words.
    task automatic test_random_layouts();
        logic [CFG_W-1:0] regs_next [NUM_REGS];
        int unsigned      run;
        int unsigned      pause_at;
        while (words_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                regs_next[REG_BLOCK_COUNT] = CFG_W'($urandom_range(1, BLOCK_LIMIT));
                for (int b = 0; b < SIZE_REGS; b++)
                    regs_next[REG_BLOCK_SIZE_0 + b] = CFG_W'($urandom_range(1, 4));
            end
            else
            begin
                for (int r = 0; r < NUM_REGS; r++)
                    regs_next[r] = CFG_W'($urandom_range(0, 7));
            end
            load_layout(regs_next[REG_BLOCK_COUNT], regs_next[REG_BLOCK_SIZE_0],
                        regs_next[REG_BLOCK_SIZE_1], regs_next[REG_BLOCK_SIZE_2],
                        regs_next[REG_BLOCK_SIZE_3]);
            run      = $urandom_range(40, 120);
            pause_at = $urandom_range(1, run);
            for (int i = 0; i < run; i++)
            begin
                // Part way through the run the sender waits for the pipeline to empty.
                if (i == pause_at)
                    wait_for_results();
                send_word(random_word());
            end
        end
    endtask

    // Stimulus sequence.
    initial
    begin
        rst_n            <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_index        <= REG_BLOCK_COUNT;
        cfg_wdata        <= '0;
        word_ch.valid    <= 1'b0;
        word_ch.payload  <= '0;
        words_sent       = 0;
        burst_left       = 0;
        red_state        = '0;
        code_regs[REG_BLOCK_COUNT]  = RST_BLOCK_COUNT;
        code_regs[REG_BLOCK_SIZE_0] = RST_BLOCK_SIZE_0;
        code_regs[REG_BLOCK_SIZE_1] = RST_BLOCK_SIZE_1;
        code_regs[REG_BLOCK_SIZE_2] = RST_BLOCK_SIZE_2;
        code_regs[REG_BLOCK_SIZE_3] = RST_BLOCK_SIZE_3;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_layout();
        test_special_layouts();
        test_unmapped_index();
        test_random_layouts();

        wait_for_results();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Receiver stalls: the mode is drawn anew whenever its stretch runs out, including stretches with none.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_e'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 96);
        end
        else
            stall_left--;
        stall_phase++;
        case (stall_mode)
            STALL_NONE:    result_ch.ready <= 1'b1;
            STALL_RANDOM:  result_ch.ready <= 1'($urandom_range(0, 1));
            STALL_PATTERN: result_ch.ready <= ((stall_phase % 5) != 0);
            default:       result_ch.ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // Compare each result transfer with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got_result = result_ch.payload;
            if (expected_results.size() == 0)
            begin
                $error("Result transfer with no word pending: data_out %h", got_result.data_out);
                mismatch_count++;
            end
            else
            begin
                want_result = expected_results.pop_front();
                if (got_result.data_out !== want_result.data_out)
                begin
                    $error("data_out: expected %h, got %h",
                           want_result.data_out, got_result.data_out);
                    mismatch_count++;
                end
                if (got_result.redundancy_out !== want_result.redundancy_out)
                begin
                    $error("redundancy_out: expected %h, got %h",
                           want_result.redundancy_out, got_result.redundancy_out);
                    mismatch_count++;
                end
                if (got_result.config_fault !== want_result.config_fault)
                begin
                    $error("config_fault: expected %b, got %b",
                           want_result.config_fault, got_result.config_fault);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule

>>> filelist.f
rtl/core/dsee_pkg.sv
rtl/core/dsee_stream_if.sv
rtl/core/dsee_cfg.sv
rtl/core/dsee_colgen.sv
rtl/core/dsee_datapath.sv
rtl/core/differential_syndrome_ecc_encoder.sv
tb/differential_syndrome_ecc_encoder_tb.sv
